// File: hdl/lkc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkc_pkg: shared types and constants of the LRU key cache
// Sizes of the entry store, field widths, operation codes, sequencer states
// and the request and result words passed between top level and engine.
// ----------------------------------------------------------------------------
package lkc_pkg;

  // Entry store
  localparam int MAX_ENTRIES = 128;
  localparam int KEY_BITS    = 48;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int RANK_W      = IDX_W;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int RAM_W       = KEY_BITS + RANK_W;

  // Capacity register
  localparam int              CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(1);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(99);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

  // Result field widths
  localparam int SLOT_W = 7;
  localparam int DROP_W = 7;
  localparam int SIZE_W = 7;

  // Stream words
  localparam int IN_DATA_W  = ((KEY_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 1 + SLOT_W + 1 + KEY_BITS + DROP_W + SIZE_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [KEY_BITS-1:0] key;
  } lkc_req_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   size;
    logic [DROP_W-1:0]   dropped_count;
    logic [KEY_BITS-1:0] evicted_key;
    logic                evicted;
    logic [SLOT_W-1:0]   slot;
    logic                hit;
  } lkc_result_t;

endpackage
`default_nettype wire

// File: hdl/lru_key_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_cache: fully associative LRU cache of packed plan keys
// Top level: stream ports, capacity register and result output register.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request word: tuser is the op (0 lookup/insert,
//   1 clear), tdata the key. m_axis returns one result word per request.
//   cfg_* writes the capacity; values outside 1..99 are dropped. Write it
//   only while the cache is idle.
// Timing:
//   A clear writes its result straight into the engine's result register;
//   the result word then passes on to the output register. A lookup runs
//   two sweeps over all 128 slots of the key/rank RAM, one slot per cycle
//   through a single rank subtractor. s_axis_tready stays low until the
//   engine has handed its result on and gone back to idle.
// Reset:
//   The cache comes up empty with capacity 10; valid bits clear at once, so
//   no clearing pass is needed.
// Stall:
//   The result sits in an output register; the next request is accepted
//   while it waits, and the engine holds its finished result until the
//   register frees up.
// ----------------------------------------------------------------------------
module lru_key_cache (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request: tdata = key; tuser = op
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [lkc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic [0:0]                     s_axis_tuser,
  // result: tdata = hit, slot, evicted, evicted_key, dropped_count, size
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [lkc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // capacity write
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [lkc_pkg::CAP_W-1:0]      cfg_data_i
);

  logic [lkc_pkg::CAP_W-1:0] cap_q, cap_d;
  logic                      m_valid_q, m_valid_d;
  lkc_pkg::lkc_result_t      m_data_q, m_data_d;

  lkc_pkg::lkc_req_t    req;
  lkc_pkg::lkc_result_t res;
  logic                 res_valid;
  logic                 res_ready;

  assign req.op  = lkc_pkg::op_e'(s_axis_tuser[0]);
  assign req.key = s_axis_tdata[lkc_pkg::KEY_BITS-1:0];

  lkc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .cap_i       (cap_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Capacity register, out-of-range writes ignored
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cap_d = cap_q;
    if (cfg_valid_i && (cfg_data_i >= lkc_pkg::CAP_MIN)
        && (cfg_data_i <= lkc_pkg::CAP_MAX)) begin
      cap_d = cfg_data_i;
    end
  end

  // Output register
  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (res_valid && res_ready) begin
      m_valid_d = 1'b1;
      m_data_d  = res;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= lkc_pkg::CAP_RESET;
      m_valid_q <= 1'b0;
    end else begin
      cap_q     <= cap_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = lkc_pkg::OUT_DATA_W'(m_data_q);

endmodule
`default_nettype wire

// File: hdl/lkc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hdl/lkc_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkc_engine: sweep sequencer of the LRU key cache
// Keys and recency ranks live in one RAM. A lookup takes two read-modify-
// write sweeps over every slot through one shared rank subtractor: the first
// trims, searches and finds the free and least recent slots, the second
// reorders ranks, evicts and inserts. Valid bits are flip-flops cleared at reset.
// ----------------------------------------------------------------------------
module lkc_engine (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      req_valid_i,
  output logic                           req_ready_o,
  input  wire lkc_pkg::lkc_req_t         req_i,
  input  wire logic [lkc_pkg::CAP_W-1:0] cap_i,
  output logic                           res_valid_o,
  input  wire logic                      res_ready_i,
  output lkc_pkg::lkc_result_t           res_o
);

  localparam int IDX_W  = lkc_pkg::IDX_W;
  localparam int RANK_W = lkc_pkg::RANK_W;
  localparam int CNT_W  = lkc_pkg::CNT_W;
  localparam int KEY_W  = lkc_pkg::KEY_BITS;
  localparam int NENT   = lkc_pkg::MAX_ENTRIES;

  lkc_pkg::state_e state_q, state_d;

  logic [IDX_W:0]         rd_q, rd_d;
  logic                   pv_q, pv_d;
  logic [IDX_W-1:0]       pidx_q, pidx_d;
  logic [NENT-1:0]        valid_q, valid_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       n_q, n_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic                   found_q, found_d;
  logic [IDX_W-1:0]       f_q, f_d;
  logic [RANK_W-1:0]      fr_q, fr_d;
  logic                   free_found_q, free_found_d;
  logic [IDX_W-1:0]       free_q, free_d;
  logic                   lru_found_q, lru_found_d;
  logic [IDX_W-1:0]       lru_q, lru_d;
  logic [KEY_W-1:0]       lru_key_q, lru_key_d;
  logic                   evict_q, evict_d;
  logic [IDX_W-1:0]       ins_q, ins_d;
  lkc_pkg::lkc_result_t   res_q, res_d;

  // RAM port signals
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [lkc_pkg::RAM_W-1:0] ram_wdata;
  logic [lkc_pkg::RAM_W-1:0] ram_rdata;

  // Current entry and shared rank subtractor
  logic [RANK_W-1:0] rk;
  logic [KEY_W-1:0]  ek;
  logic [RANK_W-1:0] sub_amt;
  logic [RANK_W:0]   diff;
  logic              borrow;
  logic [RANK_W-1:0] rk_sub;

  logic              issue;
  logic              cap_big;
  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W-1:0]  trim_n;

  lkc_ram #(
    .WIDTH (lkc_pkg::RAM_W),
    .DEPTH (NENT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Effective capacity and trim amount
  assign cap_big = (32'(cap_i) > 32'(NENT));
  assign cap_eff = cap_big ? CNT_W'(NENT) : CNT_W'(cap_i);
  assign trim_n  = (count_q > cap_eff) ? (count_q - cap_eff) : '0;

  assign rk = ram_rdata[RANK_W-1:0];
  assign ek = ram_rdata[RANK_W +: KEY_W];

  // One subtractor serves both sweeps: trim by n, then age by one
  assign sub_amt = (state_q == lkc_pkg::ST_SCAN) ? RANK_W'(n_q) : RANK_W'(1);
  assign diff    = {1'b0, rk} - {1'b0, sub_amt};
  assign borrow  = diff[RANK_W];
  assign rk_sub  = diff[RANK_W-1:0];

  assign issue = ((state_q == lkc_pkg::ST_SCAN) || (state_q == lkc_pkg::ST_UPDATE))
                 && (rd_q < (IDX_W + 1)'(NENT));

  assign req_ready_o = (state_q == lkc_pkg::ST_IDLE);
  assign res_valid_o = (state_q == lkc_pkg::ST_DONE);
  assign res_o       = res_q;

  // State and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkc_pkg::ST_IDLE;
      rd_q    <= '0;
      pv_q    <= 1'b0;
      valid_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      rd_q    <= rd_d;
      pv_q    <= pv_d;
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q       <= pidx_d;
    n_q          <= n_d;
    key_q        <= key_d;
    found_q      <= found_d;
    f_q          <= f_d;
    fr_q         <= fr_d;
    free_found_q <= free_found_d;
    free_q       <= free_d;
    lru_found_q  <= lru_found_d;
    lru_q        <= lru_d;
    lru_key_q    <= lru_key_d;
    evict_q      <= evict_d;
    ins_q        <= ins_d;
    res_q        <= res_d;
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    rd_d         = rd_q;
    pv_d         = issue;
    pidx_d       = rd_q[IDX_W-1:0];
    valid_d      = valid_q;
    count_d      = count_q;
    n_d          = n_q;
    key_d        = key_q;
    found_d      = found_q;
    f_d          = f_q;
    fr_d         = fr_q;
    free_found_d = free_found_q;
    free_d       = free_q;
    lru_found_d  = lru_found_q;
    lru_d        = lru_q;
    lru_key_d    = lru_key_q;
    evict_d      = evict_q;
    ins_d        = ins_q;
    res_d        = res_q;
    ram_we       = 1'b0;
    ram_waddr    = pidx_q;
    ram_wdata    = ram_rdata;

    if (issue) begin
      rd_d = rd_q + 1'b1;
    end

    unique case (state_q)
      lkc_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          if (req_i.op == lkc_pkg::OP_CLEAR) begin
            // Clear drops everything at once; trim is folded into the count
            res_d               = '0;
            res_d.dropped_count = lkc_pkg::DROP_W'(count_q);
            valid_d             = '0;
            count_d             = '0;
            state_d             = lkc_pkg::ST_DONE;
          end else begin
            n_d          = trim_n;
            count_d      = count_q - trim_n;
            key_d        = req_i.key;
            found_d      = 1'b0;
            free_found_d = 1'b0;
            lru_found_d  = 1'b0;
            rd_d         = '0;
            state_d      = lkc_pkg::ST_SCAN;
          end
        end
      end

      lkc_pkg::ST_SCAN: begin
        if (pv_q) begin
          if (valid_q[pidx_q] && !borrow) begin
            // Survives the trim: age, compare, look for the oldest
            ram_we    = 1'b1;
            ram_wdata = {ek, rk_sub};
            if (!found_d && (ek == key_q)) begin
              found_d = 1'b1;
              f_d     = pidx_q;
              fr_d    = rk_sub;
            end
            if (rk_sub == '0) begin
              lru_found_d = 1'b1;
              lru_d       = pidx_q;
              lru_key_d   = ek;
            end
          end else begin
            valid_d[pidx_q] = 1'b0;
            if (!free_found_d) begin
              free_found_d = 1'b1;
              free_d       = pidx_q;
            end
          end
        end
        if (!issue && !pv_q) begin
          evict_d = !found_q && (count_q >= cap_eff);
          if (!found_q && (count_q >= cap_eff)) begin
            ins_d = (free_found_q && (free_q < lru_q)) ? free_q : lru_q;
          end else begin
            ins_d = free_q;
          end
          rd_d    = '0;
          state_d = lkc_pkg::ST_UPDATE;
        end
      end

      lkc_pkg::ST_UPDATE: begin
        if (pv_q) begin
          priority if (!found_q && (pidx_q == ins_q)) begin
            ram_we          = 1'b1;
            ram_wdata       = {key_q, evict_q ? RANK_W'(count_q - 1'b1)
                                              : RANK_W'(count_q)};
            valid_d[pidx_q] = 1'b1;
          end else if (valid_q[pidx_q] && found_q) begin
            if (pidx_q == f_q) begin
              ram_we    = 1'b1;
              ram_wdata = {ek, RANK_W'(count_q - 1'b1)};
            end else if (rk > fr_q) begin
              ram_we    = 1'b1;
              ram_wdata = {ek, rk_sub};
            end
          end else if (valid_q[pidx_q] && evict_q) begin
            if (pidx_q == lru_q) begin
              valid_d[pidx_q] = 1'b0;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = {ek, rk_sub};
            end
          end else begin
            ram_we = 1'b0;
          end
        end
        if (!issue && !pv_q) begin
          res_d.hit           = found_q;
          res_d.slot          = lkc_pkg::SLOT_W'(found_q ? f_q : ins_q);
          res_d.evicted       = evict_q;
          res_d.evicted_key   = evict_q ? lru_key_q : '0;
          res_d.dropped_count = lkc_pkg::DROP_W'(n_q);
          if (!found_q && !evict_q) begin
            count_d          = count_q + 1'b1;
            res_d.size       = lkc_pkg::SIZE_W'(count_q + 1'b1);
          end else begin
            res_d.size       = lkc_pkg::SIZE_W'(count_q);
          end
          state_d = lkc_pkg::ST_DONE;
        end
      end

      lkc_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = lkc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lkc_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Fill count tracks the valid bits between items
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkc_pkg::ST_IDLE) |-> ($countones(valid_q) == 32'(count_q)))
    else $error("entry count out of step with valid bits");

  // An eviction always has a least recent entry to take
  a_evict_has_lru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lkc_pkg::ST_UPDATE) && evict_q) |-> lru_found_q)
    else $error("eviction without a least recent entry");

  // A plain insert always finds a free slot
  a_insert_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lkc_pkg::ST_UPDATE) && !found_q && !evict_q) |-> free_found_q)
    else $error("insert without a free slot");

  // Fill never exceeds the capacity after a lookup or a clear
  a_size_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(state_q == lkc_pkg::ST_DONE) && (state_q == lkc_pkg::ST_DONE))
      |-> (32'(count_q) <= 32'(cap_eff)))
    else $error("fill above capacity");
`endif

endmodule
`default_nettype wire
